// ===== design/rbst_pkg.sv =====
// package: widths, types and fixed-point helpers for the ray/box slab test
`default_nettype none
package rbst_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int N_AXES      = 3;

  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = DIFF_W + COORD_WIDTH;
  localparam int SHR_W  = PROD_W - FRAC_BITS;
  localparam int DIST_W = 64;
  localparam int EXT_W  = (SHR_W > DIST_W) ? SHR_W : DIST_W;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [DIST_W-1:0]      dist_t;

  localparam logic signed [EXT_W-1:0] EXT_MAX = {{(EXT_W-DIST_W+1){1'b0}}, {(DIST_W-1){1'b1}}};
  localparam logic signed [EXT_W-1:0] EXT_MIN = {{(EXT_W-DIST_W+1){1'b1}}, {(DIST_W-1){1'b0}}};
  localparam dist_t OUT_MAX = {{(DIST_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam dist_t OUT_MIN = -OUT_MAX - dist_t'(1);

  // floor shift of the full product, then clamp to the 64-bit distance range
  function automatic dist_t sat_dist(input prod_t p);
    logic signed [SHR_W-1:0] q;
    logic signed [EXT_W-1:0] e;
    dist_t                   r;
    q = SHR_W'(p >>> FRAC_BITS);
    e = EXT_W'(q);
    if (e > EXT_MAX) begin
      r = EXT_MAX[DIST_W-1:0];
    end else if (e < EXT_MIN) begin
      r = EXT_MIN[DIST_W-1:0];
    end else begin
      r = e[DIST_W-1:0];
    end
    return r;
  endfunction

  function automatic coord_t sat_out(input dist_t v);
    dist_t c;
    c = v;
    if (c > OUT_MAX) c = OUT_MAX;
    if (c < OUT_MIN) c = OUT_MIN;
    return c[COORD_WIDTH-1:0];
  endfunction

  function automatic dist_t dmin(input dist_t a, input dist_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic dist_t dmax(input dist_t a, input dist_t b);
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

// ===== design/rbst_if.sv =====
// channel interfaces: ray/box items in, hit results out
`default_nettype none
interface rbst_in_if;
  logic                  valid;
  logic                  ready;
  rbst_pkg::coord_t      origin_x;
  rbst_pkg::coord_t      origin_y;
  rbst_pkg::coord_t      origin_z;
  rbst_pkg::coord_t      inv_dir_x;
  rbst_pkg::coord_t      inv_dir_y;
  rbst_pkg::coord_t      inv_dir_z;
  rbst_pkg::coord_t      box_min_x;
  rbst_pkg::coord_t      box_min_y;
  rbst_pkg::coord_t      box_min_z;
  rbst_pkg::coord_t      box_max_x;
  rbst_pkg::coord_t      box_max_y;
  rbst_pkg::coord_t      box_max_z;

  modport source (
    output valid, origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

interface rbst_out_if;
  logic             valid;
  logic             ready;
  logic             hit;
  rbst_pkg::coord_t t_near;
  rbst_pkg::coord_t t_far;

  modport source (output valid, hit, t_near, t_far, input ready);
  modport sink   (input valid, hit, t_near, t_far, output ready);
endinterface
`default_nettype wire

// ===== design/ray_box_slab_test.sv =====
// ray_box_slab_test: pipelined ray versus axis-aligned box slab test
// throughput: one transaction per cycle unless stalled; three axis lanes run side by side,
//   each with two 33x32 multipliers, and the merge narrows y then z a stage each
// reset: rst_n (synchronous, active low) clears all stage valid bits; payload
//   registers are not reset
`default_nettype none
module ray_box_slab_test (
  input  wire logic clk,
  input  wire logic rst_n,
  rbst_in_if.sink   in_ch,
  rbst_out_if.source out_ch
);
  import rbst_pkg::*;

  localparam int DEPTH = 5;   // stages before the output register

  // whole pipeline moves together when the output register is free or drains
  logic adv;
  logic in_fire;
  logic [DEPTH-1:0] v_r, v_nxt;
  logic out_valid_r;
  logic out_hit_r;
  coord_t out_near_r, out_far_r;

  coord_t org  [N_AXES];
  coord_t inv  [N_AXES];
  coord_t bmin [N_AXES];
  coord_t bmax [N_AXES];
  dist_t  t1   [N_AXES];
  dist_t  t2   [N_AXES];
  dist_t  t_min, t_max;
  logic   hit_nxt;

  assign adv     = !out_valid_r || out_ch.ready;
  assign in_fire = in_ch.valid && adv;
  assign in_ch.ready = adv;

  // regroup item fields by axis for the lanes
  assign org[0]  = in_ch.origin_x;
  assign org[1]  = in_ch.origin_y;
  assign org[2]  = in_ch.origin_z;
  assign inv[0]  = in_ch.inv_dir_x;
  assign inv[1]  = in_ch.inv_dir_y;
  assign inv[2]  = in_ch.inv_dir_z;
  assign bmin[0] = in_ch.box_min_x;
  assign bmin[1] = in_ch.box_min_y;
  assign bmin[2] = in_ch.box_min_z;
  assign bmax[0] = in_ch.box_max_x;
  assign bmax[1] = in_ch.box_max_y;
  assign bmax[2] = in_ch.box_max_z;

  // one lane per axis: differences (stage 1), products (stage 2)
  for (genvar a = 0; a < N_AXES; a++) begin : g_lane
    rbst_lane u_lane (
      .clk     (clk),
      .adv     (adv),
      .origin  (org[a]),
      .inv_dir (inv[a]),
      .box_min (bmin[a]),
      .box_max (bmax[a]),
      .t1      (t1[a]),
      .t2      (t2[a])
    );
  end

  // x slab (stage 3), y narrowing (stage 4), z narrowing (stage 5)
  rbst_merge u_merge (
    .clk   (clk),
    .adv   (adv),
    .t1    (t1),
    .t2    (t2),
    .t_min (t_min),
    .t_max (t_max)
  );

  // hit uses the distances before the output clamp
  assign hit_nxt = t_max > dmax(t_min, '0);
  assign v_nxt   = {v_r[DEPTH-2:0], in_fire};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= v_nxt;
      out_valid_r <= v_r[DEPTH-1];
    end
  end

  // output register, stage 6
  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r  <= hit_nxt;
      out_near_r <= sat_out(t_min);
      out_far_r  <= sat_out(t_max);
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.hit    = out_hit_r;
  assign out_ch.t_near = out_near_r;
  assign out_ch.t_far  = out_far_r;

  // a hit means exit is positive and not before entry, even after clamping
  a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.hit |-> (out_ch.t_far > 0) && (out_ch.t_far >= out_ch.t_near))
    else $error("hit result with exit not past entry");

  // a stalled pipeline keeps every stage's valid bit
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r) && out_valid_r)
    else $error("pipeline moved during stall");

  // the last stage lands in the output register when the pipeline advances
  a_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
    adv && v_r[DEPTH-1] |=> out_valid_r)
    else $error("transaction lost before output register");
endmodule
`default_nettype wire

// ===== design/rbst_lane.sv =====
// one axis lane: slab differences, products and saturated slab distances
`default_nettype none
module rbst_lane (
  input  wire logic             clk,
  input  wire logic             adv,
  input  wire rbst_pkg::coord_t origin,
  input  wire rbst_pkg::coord_t inv_dir,
  input  wire rbst_pkg::coord_t box_min,
  input  wire rbst_pkg::coord_t box_max,
  output rbst_pkg::dist_t       t1,
  output rbst_pkg::dist_t       t2
);
  import rbst_pkg::*;

  diff_t  d1_r, d2_r;
  coord_t inv_r;
  prod_t  p1_r, p2_r;

  // stage 1: exact differences, one bit wider
  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r  <= DIFF_W'(box_min) - DIFF_W'(origin);
      d2_r  <= DIFF_W'(box_max) - DIFF_W'(origin);
      inv_r <= inv_dir;
    end
  end

  // stage 2: full signed products
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r <= PROD_W'(d1_r) * PROD_W'(inv_r);
      p2_r <= PROD_W'(d2_r) * PROD_W'(inv_r);
    end
  end

  assign t1 = sat_dist(p1_r);
  assign t2 = sat_dist(p2_r);
endmodule
`default_nettype wire

// ===== design/rbst_merge.sv =====
// merge of the three lanes: x slab, then y and z narrowing, one stage each
`default_nettype none
module rbst_merge (
  input  wire logic            clk,
  input  wire logic            adv,
  input  wire rbst_pkg::dist_t t1 [rbst_pkg::N_AXES],
  input  wire rbst_pkg::dist_t t2 [rbst_pkg::N_AXES],
  output rbst_pkg::dist_t      t_min,
  output rbst_pkg::dist_t      t_max
);
  import rbst_pkg::*;

  dist_t xmin_r, xmax_r, y1_r, y2_r, z1_r, z2_r;
  dist_t ymin_r, ymax_r, z1b_r, z2b_r;
  dist_t zmin_r, zmax_r;
  dist_t ymin_nxt, ymax_nxt, zmin_nxt, zmax_nxt;

  always_comb begin
    ymin_nxt = dmax(xmin_r, dmin(dmin(y1_r, y2_r), xmax_r));
    ymax_nxt = dmin(xmax_r, dmax(dmax(y1_r, y2_r), ymin_nxt));
    zmin_nxt = dmax(ymin_r, dmin(dmin(z1b_r, z2b_r), ymax_r));
    zmax_nxt = dmin(ymax_r, dmax(dmax(z1b_r, z2b_r), zmin_nxt));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xmin_r <= dmin(t1[0], t2[0]);
      xmax_r <= dmax(t1[0], t2[0]);
      y1_r   <= t1[1];
      y2_r   <= t2[1];
      z1_r   <= t1[2];
      z2_r   <= t2[2];
      ymin_r <= ymin_nxt;
      ymax_r <= ymax_nxt;
      z1b_r  <= z1_r;
      z2b_r  <= z2_r;
      zmin_r <= zmin_nxt;
      zmax_r <= zmax_nxt;
    end
  end

  assign t_min = zmin_r;
  assign t_max = zmax_r;
endmodule
`default_nettype wire

// ===== dv/rbst_slab_checker.sv =====
// checker for the ray/box slab test: predicts each result and compares it with the block's output
module rbst_slab_checker (
  input  logic clk,
  input  logic rst_n,
  rbst_in_if   in_mon,
  rbst_out_if  out_mon,
  output int   fail_count,
  output int   pending_count,
  output int   result_count,
  output int   hit_count
);
  import rbst_pkg::*;

  localparam int     CW         = COORD_WIDTH;
  localparam int     REPORT_CAP = 40;
  localparam longint DIST_HI    = 64'sh7fff_ffff_ffff_ffff;
  localparam longint DIST_LO    = -DIST_HI - 64'sd1;
  localparam longint COORD_HI   = (64'sd1 <<< (CW - 1)) - 64'sd1;
  localparam longint COORD_LO   = -COORD_HI - 64'sd1;

  typedef logic [2:0][CW-1:0] axes_t;

  typedef struct packed {
    logic   hit;
    coord_t t_near;
    coord_t t_far;
  } slab_result_t;

  slab_result_t expected_q[$];
  slab_result_t want;
  int           mismatches = 0;
  int           results    = 0;
  int           hits       = 0;

  function automatic longint lesser(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint greater(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > COORD_HI) return coord_t'(COORD_HI);
    if (v < COORD_LO) return coord_t'(COORD_LO);
    return coord_t'(v);
  endfunction

  // (bound - origin) * inv, floor shift, clamped to the 64-bit distance range
  function automatic longint slab_dist(coord_t org, coord_t bound, coord_t inv);
    logic signed [CW:0]     diff;
    logic signed [2*CW+1:0] prod;
    logic signed [2*CW+1:0] shifted;
    diff = {bound[CW-1], bound} - {org[CW-1], org};
    prod = diff * inv;
    shifted = prod >>> FRAC_BITS;
    if (shifted > DIST_HI) return DIST_HI;
    if (shifted < DIST_LO) return DIST_LO;
    return longint'(shifted);
  endfunction

  // x sets the interval, y and z narrow it; exit uses the freshly narrowed entry
  function automatic slab_result_t predict_slab(axes_t org, axes_t inv, axes_t lo, axes_t hi);
    longint       t1;
    longint       t2;
    longint       t_in;
    longint       t_out;
    int           a;
    slab_result_t r;
    t1    = slab_dist(org[0], lo[0], inv[0]);
    t2    = slab_dist(org[0], hi[0], inv[0]);
    t_in  = lesser(t1, t2);
    t_out = greater(t1, t2);
    for (a = 1; a < 3; a++) begin
      t1    = slab_dist(org[a], lo[a], inv[a]);
      t2    = slab_dist(org[a], hi[a], inv[a]);
      t_in  = greater(t_in, lesser(lesser(t1, t2), t_out));
      t_out = lesser(t_out, greater(greater(t1, t2), t_in));
    end
    r.hit    = t_out > greater(t_in, 64'sd0);
    r.t_near = clamp_coord(t_in);
    r.t_far  = clamp_coord(t_out);
    return r;
  endfunction

  task automatic report_mismatch(string field, longint want_v, longint got_v);
    mismatches++;
    if (mismatches <= REPORT_CAP) begin
      $error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        expected_q.push_back(predict_slab(
          {in_mon.origin_z, in_mon.origin_y, in_mon.origin_x},
          {in_mon.inv_dir_z, in_mon.inv_dir_y, in_mon.inv_dir_x},
          {in_mon.box_min_z, in_mon.box_min_y, in_mon.box_min_x},
          {in_mon.box_max_z, in_mon.box_max_y, in_mon.box_max_x}));
      end
      if (out_mon.valid && out_mon.ready) begin
        results++;
        if (out_mon.hit === 1'b1) hits++;
        if (expected_q.size() == 0) begin
          mismatches++;
          $error("unexpected result transaction: hit %0b, t_near %0d, t_far %0d",
                 out_mon.hit, out_mon.t_near, out_mon.t_far);
        end else begin
          want = expected_q.pop_front();
          if (out_mon.hit !== want.hit) report_mismatch("hit", want.hit, out_mon.hit);
          if (out_mon.t_near !== want.t_near) begin
            report_mismatch("t_near", want.t_near, out_mon.t_near);
          end
          if (out_mon.t_far !== want.t_far) begin
            report_mismatch("t_far", want.t_far, out_mon.t_far);
          end
        end
      end
    end
    fail_count    <= mismatches;
    pending_count <= expected_q.size();
    result_count  <= results;
    hit_count     <= hits;
  end

endmodule

// ===== dv/tb.sv =====
// testbench top: clock, reset, ray/box stimulus, output stalls and the verdict
module tb;
  import rbst_pkg::*;

  localparam int     CW           = COORD_WIDTH;
  localparam int     FB           = FRAC_BITS;
  localparam int     RANDOM_ITEMS = 1050;
  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     DRAIN_CYCLES = 16;
  localparam coord_t ONE          = coord_t'(1) <<< FB;
  localparam coord_t C_MAX        = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t C_MIN        = {1'b1, {(CW-1){1'b0}}};

  typedef logic [2:0][CW-1:0] axes_t;

  typedef struct packed {
    axes_t org;
    axes_t inv;
    axes_t lo;
    axes_t hi;
  } ray_box_t;

  // flavors of random transaction
  typedef enum int { SHAPE_SCENE, SHAPE_WIDE, SHAPE_NOISE, SHAPE_CORNER } shape_e;
  // output-side stall behavior, switched every so often
  typedef enum int { RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BURSTY } rx_mode_e;

  logic        clk;
  logic        rst_n;
  int unsigned cycles = 0;
  int          fail_count;
  int          pending_count;
  int          result_count;
  int          hit_count;
  int          sent_total = 0;
  int          burst_left = 0;
  rx_mode_e    rx_mode = RX_OPEN;
  int          rx_mode_left = 0;
  int          rx_stall_left = 0;

  rbst_in_if  in_ch ();
  rbst_out_if out_ch ();

  ray_box_slab_test DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rbst_slab_checker slab_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .result_count  (result_count),
    .hit_count     (hit_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) cycles <= cycles + 1;

  // watchdog: a hung handshake ends the run here
  initial begin : watchdog
    wait (cycles >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // output stalls: open, lightly stalled, heavily stalled, or long stall runs
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(20, 200);
    end else begin
      rx_mode_left = rx_mode_left - 1;
    end
    case (rx_mode)
      RX_OPEN: begin
        out_ch.ready <= 1'b1;
      end
      RX_LIGHT: begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
      RX_HEAVY: begin
        out_ch.ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        if (rx_stall_left > 0) begin
          rx_stall_left = rx_stall_left - 1;
          out_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
          rx_stall_left = $urandom_range(4, 16);
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    endcase
  end

  function automatic int rnd_span(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  // same ray and slab on all three axes
  function automatic ray_box_t uniform(coord_t o, coord_t v, coord_t lo, coord_t hi);
    ray_box_t it;
    int       a;
    for (a = 0; a < 3; a++) begin
      it.org[a] = o;
      it.inv[a] = v;
      it.lo[a]  = lo;
      it.hi[a]  = hi;
    end
    return it;
  endfunction

  function automatic coord_t corner_value();
    case ($urandom_range(0, 7))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return '0;
      3:       return coord_t'(1);
      4:       return -coord_t'(1);
      5:       return ONE;
      6:       return -ONE;
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic drive_fields(ray_box_t it);
    in_ch.origin_x  <= it.org[0];
    in_ch.origin_y  <= it.org[1];
    in_ch.origin_z  <= it.org[2];
    in_ch.inv_dir_x <= it.inv[0];
    in_ch.inv_dir_y <= it.inv[1];
    in_ch.inv_dir_z <= it.inv[2];
    in_ch.box_min_x <= it.lo[0];
    in_ch.box_min_y <= it.lo[1];
    in_ch.box_min_z <= it.lo[2];
    in_ch.box_max_x <= it.hi[0];
    in_ch.box_max_y <= it.hi[1];
    in_ch.box_max_z <= it.hi[2];
  endtask

  // one transaction; a new burst may open with a gap, and each burst then runs gap-free
  task automatic send_ray_box(ray_box_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 96) : $urandom_range(1, 16);
      gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    drive_fields(it);
    do @(posedge clk); while (!in_ch.ready);
    sent_total++;
  endtask

  // hold the input off until every predicted result has come back
  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  initial begin : stimulus
    ray_box_t it;
    int       i;
    int       a;
    int       pick;
    int       n_directed;
    shape_e   shape;
    longint   c;
    longint   half;
    longint   o;
    longint   d;
    coord_t   p;
    coord_t   q;

    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    drive_fields('0);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    // ray along +1 into a box ahead: entry 1, exit 2, hit
    send_ray_box(uniform('0, ONE, ONE, 2 * ONE));
    // box behind the origin: miss
    send_ray_box(uniform('0, ONE, -2 * ONE, -ONE));
    // origin inside the box: negative entry, still a hit
    send_ray_box(uniform('0, ONE, -ONE, ONE));
    // negative direction away from the box
    send_ray_box(uniform('0, -ONE, ONE, 2 * ONE));
    // zero y direction (saturated inverse), origin inside the y slab
    it = uniform('0, ONE, -ONE, ONE);
    it.inv[1] = C_MAX;
    send_ray_box(it);
    // zero y direction, origin outside the y slab: miss
    it = uniform('0, ONE, ONE, 2 * ONE);
    it.inv[1] = C_MAX;
    it.org[1] = '0;
    send_ray_box(it);
    // origin on the box face: zero difference gives distance 0
    send_ray_box(uniform(ONE, ONE, ONE, 3 * ONE));
    // zero inverse everywhere: all distances 0
    send_ray_box(uniform('0, '0, ONE, 2 * ONE));
    // inverted box, min above max
    send_ray_box(uniform('0, ONE, 2 * ONE, ONE));
    // x and y slabs only touch: entry equals exit, miss
    it = uniform('0, ONE, ONE, 2 * ONE);
    it.lo[1] = 2 * ONE;
    it.hi[1] = 3 * ONE;
    send_ray_box(it);
    // exit exactly at the origin: miss
    send_ray_box(uniform('0, ONE, -2 * ONE, '0));
    // floor rounding of a tiny negative product, then a tiny positive one
    send_ray_box(uniform('0, -coord_t'(1), coord_t'(1), coord_t'(2)));
    send_ray_box(uniform('0, coord_t'(1), coord_t'(1), coord_t'(2)));
    // field extremes
    send_ray_box(uniform(C_MAX, C_MAX, C_MAX, C_MAX));
    send_ray_box(uniform(C_MIN, C_MIN, C_MIN, C_MIN));
    // widest difference times largest inverses: output saturation both ways
    send_ray_box(uniform(C_MIN, C_MAX, C_MAX, C_MAX));
    send_ray_box(uniform(C_MIN, C_MIN, C_MAX, C_MAX));
    send_ray_box(uniform(C_MAX, C_MIN, C_MIN, C_MIN));
    send_ray_box(uniform(C_MAX, C_MAX, C_MIN, C_MAX));
    send_ray_box(uniform('0, '0, '0, '0));
    send_ray_box(uniform(-coord_t'(1), -coord_t'(1), -coord_t'(1), -coord_t'(1)));
    n_directed = sent_total;
    wait_all_results();

    // ---- random part ----
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      pick  = $urandom_range(0, 9);
      shape = (pick < 6) ? SHAPE_SCENE : (pick < 8) ? SHAPE_NOISE :
              (pick == 8) ? SHAPE_CORNER : SHAPE_WIDE;
      case (shape)
        SHAPE_SCENE: begin
          // rays aimed near a random box center, so hits and near misses dominate
          for (a = 0; a < 3; a++) begin
            c    = longint'(rnd_span(48 * ONE));
            half = longint'($urandom_range(ONE / 4, 8 * ONE));
            o    = longint'(rnd_span(64 * ONE));
            d    = c + longint'(rnd_span(int'(2 * half))) - o;
            it.org[a] = coord_t'(o);
            it.lo[a]  = coord_t'(c - half);
            it.hi[a]  = coord_t'(c + half);
            if ($urandom_range(0, 9) == 0) begin
              // ray parallel to this slab, origin in or out of it
              it.org[a] = coord_t'(c + longint'(rnd_span(int'(2 * half))));
              it.inv[a] = $urandom_range(0, 1) ? C_MAX : C_MIN;
            end else if (d == 0) begin
              it.inv[a] = C_MAX;
            end else begin
              d = (64'sd1 <<< (2 * FB)) / d;
              it.inv[a] = coord_t'((d > C_MAX) ? C_MAX : (d < C_MIN) ? C_MIN : d);
            end
            if ($urandom_range(0, 19) == 0) begin
              it.lo[a] = coord_t'(c + half);
              it.hi[a] = coord_t'(c - half);
            end
          end
        end
        SHAPE_WIDE: begin
          // full-range coordinates, box corners kept in order
          for (a = 0; a < 3; a++) begin
            p = $urandom;
            q = $urandom;
            it.org[a] = $urandom;
            it.inv[a] = $urandom;
            it.lo[a]  = (p < q) ? p : q;
            it.hi[a]  = (p < q) ? q : p;
          end
        end
        SHAPE_NOISE: begin
          for (a = 0; a < 3; a++) begin
            it.org[a] = $urandom;
            it.inv[a] = $urandom;
            it.lo[a]  = $urandom;
            it.hi[a]  = $urandom;
          end
        end
        default: begin
          for (a = 0; a < 3; a++) begin
            it.org[a] = corner_value();
            it.inv[a] = corner_value();
            it.lo[a]  = corner_value();
            it.hi[a]  = corner_value();
          end
        end
      endcase
      send_ray_box(it);
      // one full drain in the middle of the random stream
      if (i == RANDOM_ITEMS / 2) wait_all_results();
    end

    // ---- wrap up ----
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d ray/box transactions: %0d directed, %0d random, bursty input, stalled output",
             sent_total, n_directed, sent_total - n_directed);
    $display("checked %0d results: %0d hits, %0d misses",
             result_count, hit_count, result_count - hit_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
